// File: sv/efhu_pkg.sv
// Package with the shared types and constants of the edge feedback Hill update core.
`default_nettype none
package efhu_pkg;
    localparam int unsigned FRACTION_BITS_DEFAULT = 16;
    localparam int unsigned VAL_W = 24;
    localparam int unsigned ORD_W = 5;
    localparam int unsigned MODE_W = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned MAX_ORDER = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAGS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_REST       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MYO_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MYO_ORDER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADH_GAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADH_ORDER      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ADH_THRESHOLD  = 3'd7;

    localparam int unsigned MODE_FEEDBACK = 0;
    localparam int unsigned MODE_BOUNDARY = 1;
    localparam int unsigned MODE_TOP      = 2;
    localparam int unsigned MODE_ADHESION = 3;
    localparam int unsigned MODE_MYO_CLMP = 4;
    localparam int unsigned MODE_ADH_CLMP = 5;
    localparam int unsigned MODE_ADH_THR  = 6;

    typedef struct packed {
        logic [VAL_W-1:0]        seg_length;
        logic                    on_boundary;
        logic                    on_top_boundary;
        logic signed [VAL_W-1:0] myosin_now;
        logic signed [VAL_W-1:0] adhesion_now;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] myosin_next;
        logic signed [VAL_W-1:0] adhesion_next;
        logic                    was_updated;
    } t_out_item;

    typedef struct packed {
        logic [VAL_W-1:0] gain;
        logic [ORD_W-1:0] order;
        logic [VAL_W-1:0] time_step;
    } t_lane_cfg;
endpackage
`default_nettype wire

// File: sv/efhu_lane.sv
// One Hill feedback lane: pipelined power, restoring divider and Euler step.
`default_nettype none
module efhu_lane #(
    parameter int unsigned FRACTION_BITS = efhu_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire efhu_pkg::t_lane_cfg             i_cfg,
    input  wire logic [efhu_pkg::VAL_W-1:0]      i_base,
    input  wire logic                            i_zero_rate,
    input  wire logic signed [efhu_pkg::VAL_W-1:0] i_value,
    output logic signed [efhu_pkg::VAL_W-1:0]    o_next
);
    import efhu_pkg::*;

    localparam int unsigned NPOW = MAX_ORDER - 1;
    localparam int unsigned NUM_W = VAL_W + FRACTION_BITS;
    localparam int unsigned DEN_W = VAL_W + 1;
    localparam int unsigned RATE_W = 64;
    localparam logic [VAL_W-1:0] MAXU = {VAL_W{1'b1}};
    localparam logic [DEN_W-1:0] ONE_D = DEN_W'(1) << FRACTION_BITS;

    // Power chain: stage k holds the power of order k+1, capped at the configured order.
    logic [VAL_W-1:0]        r_pw_base [NPOW+1];
    logic [VAL_W-1:0]        r_pw_p    [NPOW+1];
    logic [ORD_W-1:0]        r_pw_n    [NPOW+1];
    logic                    r_pw_z    [NPOW+1];
    logic signed [VAL_W-1:0] r_pw_m    [NPOW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pw_base[0] <= i_base;
            r_pw_p[0]    <= i_base;
            r_pw_n[0]    <= (i_cfg.order == '0) ? ORD_W'(1) :
                            (i_cfg.order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : i_cfg.order;
            r_pw_z[0]    <= i_zero_rate;
            r_pw_m[0]    <= i_value;
        end
    end

    for (genvar k = 1; k <= NPOW; k++) begin : g_pow
        logic [2*VAL_W-1:0] w_prod;
        logic [2*VAL_W-1:0] w_sh;
        assign w_prod = r_pw_p[k-1] * r_pw_base[k-1];
        assign w_sh   = w_prod >> FRACTION_BITS;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pw_base[k] <= r_pw_base[k-1];
                r_pw_n[k]    <= r_pw_n[k-1];
                r_pw_z[k]    <= r_pw_z[k-1];
                r_pw_m[k]    <= r_pw_m[k-1];
                if (ORD_W'(k) < r_pw_n[k-1]) begin
                    r_pw_p[k] <= (w_sh > (2*VAL_W)'(MAXU)) ? MAXU : w_sh[VAL_W-1:0];
                end else begin
                    r_pw_p[k] <= r_pw_p[k-1];
                end
            end
        end
    end

    // Restoring divider, one quotient bit per stage.
    logic [NUM_W-1:0]        r_dv_q [NUM_W+1];
    logic [DEN_W-1:0]        r_dv_r [NUM_W+1];
    logic [DEN_W-1:0]        r_dv_d [NUM_W+1];
    logic                    r_dv_z [NUM_W+1];
    logic signed [VAL_W-1:0] r_dv_m [NUM_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_q[0] <= NUM_W'(r_pw_p[NPOW]) << FRACTION_BITS;
            r_dv_r[0] <= '0;
            r_dv_d[0] <= ONE_D + DEN_W'(r_pw_p[NPOW]);
            r_dv_z[0] <= r_pw_z[NPOW];
            r_dv_m[0] <= r_pw_m[NPOW];
        end
    end

    for (genvar k = 1; k <= NUM_W; k++) begin : g_div
        logic [DEN_W:0] w_rem;
        logic           w_ge;
        assign w_rem = {r_dv_r[k-1], r_dv_q[k-1][NUM_W-1]};
        assign w_ge  = w_rem >= {1'b0, r_dv_d[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_r[k] <= w_ge ? DEN_W'(w_rem - {1'b0, r_dv_d[k-1]}) : w_rem[DEN_W-1:0];
                r_dv_q[k] <= {r_dv_q[k-1][NUM_W-2:0], w_ge};
                r_dv_d[k] <= r_dv_d[k-1];
                r_dv_z[k] <= r_dv_z[k-1];
                r_dv_m[k] <= r_dv_m[k-1];
            end
        end
    end

    // Euler step: two products, then rate, then dt product, then saturation.
    logic signed [RATE_W-1:0] r_e1_gh;
    logic signed [RATE_W-1:0] r_e1_gm;
    logic                     r_e1_z;
    logic signed [VAL_W-1:0]  r_e1_m;
    logic signed [RATE_W-1:0] r_e2_rate;
    logic signed [VAL_W-1:0]  r_e2_m;
    logic signed [RATE_W-1:0] r_e3_d;
    logic signed [VAL_W-1:0]  r_e3_m;
    logic signed [RATE_W-1:0] w_rate;
    logic signed [RATE_W-1:0] w_lim;
    logic signed [RATE_W-1:0] w_sum;

    assign w_lim  = (RATE_W'(1) <<< 38) - 1;
    assign w_rate = (r_e1_gh - r_e1_gm) >>> FRACTION_BITS;
    assign w_sum  = RATE_W'(r_e3_m) + (r_e3_d >>> FRACTION_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1_gh <= RATE_W'(signed'({1'b0, i_cfg.gain})) *
                       RATE_W'(signed'({1'b0, r_dv_q[NUM_W][VAL_W-1:0], 1'b0}));
            r_e1_gm <= RATE_W'(signed'({1'b0, i_cfg.gain})) * RATE_W'(r_dv_m[NUM_W]);
            r_e1_z  <= r_dv_z[NUM_W];
            r_e1_m  <= r_dv_m[NUM_W];
            if (r_e1_z) begin
                r_e2_rate <= '0;
            end else if (w_rate > w_lim) begin
                r_e2_rate <= w_lim;
            end else if (w_rate < -w_lim) begin
                r_e2_rate <= -w_lim;
            end else begin
                r_e2_rate <= w_rate;
            end
            r_e2_m <= r_e1_m;
            r_e3_d <= RATE_W'(signed'({1'b0, i_cfg.time_step})) * r_e2_rate;
            r_e3_m <= r_e2_m;
            if (w_sum > RATE_W'(24'sh7FFFFF)) begin
                o_next <= 24'sh7FFFFF;
            end else if (w_sum < -RATE_W'(24'sh7FFFFF) - 1) begin
                o_next <= 24'sh800000;
            end else begin
                o_next <= w_sum[VAL_W-1:0];
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/edge_feedback_hill_update_core.sv
// Top level of the edge feedback Hill update core with gating and stall control.
// Throughput: one edge per cycle; the whole pipeline advances unless a held result stalls it.
// The power chain and the bit-per-stage divider set the depth.
// Synchronous active-low reset clears valid bits and loads register reset values.
`default_nettype none
module edge_feedback_hill_update_core #(
    parameter int unsigned FRACTION_BITS = efhu_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire efhu_pkg::t_in_item                i_data,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output efhu_pkg::t_out_item                    o_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [efhu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [efhu_pkg::VAL_W-1:0]        i_cfg_data
);
    import efhu_pkg::*;

    localparam int unsigned LANE_LAT = MAX_ORDER + (VAL_W + FRACTION_BITS + 1) + 4;
    localparam int unsigned DEPTH = LANE_LAT + 1;
    localparam logic [VAL_W-1:0] ONE_S = VAL_W'(1) << FRACTION_BITS;

    logic [MODE_W-1:0] r_mode;
    logic [VAL_W-1:0]  r_inv_rest, r_myo_gain, r_adh_gain, r_dt, r_thr;
    logic [ORD_W-1:0]  r_myo_ord, r_adh_ord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= '0;
            r_inv_rest <= VAL_W'(59600);
            r_myo_gain <= VAL_W'(65536);
            r_myo_ord  <= ORD_W'(8);
            r_adh_gain <= VAL_W'(65536);
            r_adh_ord  <= ORD_W'(8);
            r_dt       <= VAL_W'(655);
            r_thr      <= VAL_W'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE_FLAGS:    r_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_INV_REST:      r_inv_rest <= i_cfg_data;
                CFG_MYO_GAIN:      r_myo_gain <= i_cfg_data;
                CFG_MYO_ORDER:     r_myo_ord  <= i_cfg_data[ORD_W-1:0];
                CFG_ADH_GAIN:      r_adh_gain <= i_cfg_data;
                CFG_ADH_ORDER:     r_adh_ord  <= i_cfg_data[ORD_W-1:0];
                CFG_TIME_STEP:     r_dt       <= i_cfg_data;
                CFG_ADH_THRESHOLD: r_thr      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_valid [DEPTH+1];
    assign w_en    = !(r_valid[DEPTH] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_valid[DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DEPTH; k++) r_valid[k] <= 1'b0;
        end else if (w_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k <= DEPTH; k++) r_valid[k] <= r_valid[k-1];
        end
    end

    // Stage 0: gating and stretch product.
    logic [2*VAL_W-1:0] w_prod;
    logic               w_go;
    logic [2*VAL_W-1:0] r_s_prod;
    logic               r_s_go;
    logic               r_s_adh;
    logic signed [VAL_W-1:0] r_s_m, r_s_a;

    assign w_go = r_mode[MODE_FEEDBACK] && !(r_mode[MODE_BOUNDARY] &&
                  (!i_data.on_boundary || (r_mode[MODE_TOP] && !i_data.on_top_boundary)));
    assign w_prod = (2*VAL_W)'(i_data.seg_length) * (2*VAL_W)'(r_inv_rest);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_prod <= w_prod;
            r_s_go   <= w_go;
            r_s_adh  <= w_go && r_mode[MODE_ADHESION];
            r_s_m    <= i_data.myosin_now;
            r_s_a    <= i_data.adhesion_now;
        end
    end

    // Stage 1: stretch, adhesion base and clamp decisions.
    logic [2*VAL_W-1:0] w_sh;
    logic [VAL_W-1:0]   w_s;
    logic [VAL_W+1:0]   w_c;
    logic [VAL_W+1:0]   w_cabs;
    logic [ORD_W-1:0]   w_an;
    logic [VAL_W-1:0]   r_myo_base, r_adh_base;
    logic               r_myo_z, r_adh_z;

    assign w_sh = r_s_prod >> FRACTION_BITS;
    assign w_s  = (w_sh > (2*VAL_W)'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} : w_sh[VAL_W-1:0];
    assign w_c  = (VAL_W+2)'(ONE_S) + (VAL_W+2)'(ONE_S) - (VAL_W+2)'(w_s);
    assign w_an = (r_adh_ord == '0) ? ORD_W'(1) :
                  (r_adh_ord > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : r_adh_ord;
    assign w_cabs = w_c[VAL_W+1] ? (w_an[0] ? '0 : (VAL_W+2)'(-w_c)) : w_c;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_myo_base <= w_s;
            r_adh_base <= (w_cabs > (VAL_W+2)'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} :
                          w_cabs[VAL_W-1:0];
            r_myo_z    <= r_mode[MODE_MYO_CLMP] && (w_s < ONE_S);
            r_adh_z    <= (r_mode[MODE_ADH_CLMP] && (w_s > ONE_S)) ||
                          (r_mode[MODE_ADH_THR] && (w_s > r_thr));
        end
    end

    // Side band that bypasses the lanes.
    logic                    r_sb_go  [DEPTH];
    logic                    r_sb_adh [DEPTH];
    logic signed [VAL_W-1:0] r_sb_m   [DEPTH];
    logic signed [VAL_W-1:0] r_sb_a   [DEPTH];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_go[0]  <= r_s_go;
            r_sb_adh[0] <= r_s_adh;
            r_sb_m[0]   <= r_s_m;
            r_sb_a[0]   <= r_s_a;
            for (int k = 1; k < DEPTH; k++) begin
                r_sb_go[k]  <= r_sb_go[k-1];
                r_sb_adh[k] <= r_sb_adh[k-1];
                r_sb_m[k]   <= r_sb_m[k-1];
                r_sb_a[k]   <= r_sb_a[k-1];
            end
        end
    end

    t_lane_cfg w_myo_cfg, w_adh_cfg;
    assign w_myo_cfg = '{gain: r_myo_gain, order: r_myo_ord, time_step: r_dt};
    assign w_adh_cfg = '{gain: r_adh_gain, order: r_adh_ord, time_step: r_dt};

    logic signed [VAL_W-1:0] w_myo_next, w_adh_next;

    efhu_lane #(.FRACTION_BITS(FRACTION_BITS)) u_myo (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(w_myo_cfg), .i_base(r_myo_base),
        .i_zero_rate(r_myo_z), .i_value(r_sb_m[0]), .o_next(w_myo_next)
    );

    efhu_lane #(.FRACTION_BITS(FRACTION_BITS)) u_adh (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(w_adh_cfg), .i_base(r_adh_base),
        .i_zero_rate(r_adh_z), .i_value(r_sb_a[0]), .o_next(w_adh_next)
    );

    assign o_data.myosin_next   = r_sb_go[DEPTH-1] ? w_myo_next : r_sb_m[DEPTH-1];
    assign o_data.adhesion_next = r_sb_adh[DEPTH-1] ? w_adh_next : r_sb_a[DEPTH-1];
    assign o_data.was_updated   = r_sb_go[DEPTH-1];
endmodule
`default_nettype wire
